// ===== rtl/core/rectangle_fill_outline_raster_core_assert.svh =====
// Assertion macros shared by the rectangle raster core.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef RECTANGLE_FILL_OUTLINE_RASTER_CORE_ASSERT_SVH
`define RECTANGLE_FILL_OUTLINE_RASTER_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define RFOR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define RFOR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rfor_pkg.sv =====
// Package for the rectangle raster core: codes, port widths and the
// controller/datapath interface types. No dependencies.
`default_nettype none

package rfor_pkg;

  // Port widths.
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Command codes carried in the input tuser.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Shape type bytes.
  localparam logic [7:0] SHAPE_FILLED  = 8'h52;  // 'R'
  localparam logic [7:0] SHAPE_OUTLINE = 8'h72;  // 'r'

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_RMUL,
    ST_RMEM,
    ST_DONE
  } rfor_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
    logic rmul;
    logic load_out;
  } rfor_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       draw_ok;
    logic       scan_last;
  } rfor_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfor_ctrl.sv =====
// Controller state machine of the rectangle raster core.
// Depends on rfor_pkg; drives the datapath through rfor_cmd_t.
`default_nettype none

module rfor_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [1:0]            in_op,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire rfor_pkg::rfor_stat_t  stat,
  output rfor_pkg::rfor_cmd_t        cmd
);
  import rfor_pkg::*;

  rfor_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_CLEAR: state_nxt = ST_SCAN;
            OP_DRAW:  state_nxt = ST_SETUP;
            OP_READ:  state_nxt = ST_RMUL;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.draw_ok ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RMUL: begin
        cmd.rmul  = 1'b1;
        state_nxt = ST_RMEM;
      end
      ST_RMEM: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/rfor_datapath.sv =====
// Datapath of the rectangle raster core: configuration registers, pixel
// scan counters, edge compares, canvas memory and result register. Uses rfor_pkg.
`default_nettype none

module rfor_datapath #(
  parameter int MAX_SIDE  = 512,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rfor_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rfor_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [rfor_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [rfor_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire rfor_pkg::rfor_cmd_t               cmd,
  output rfor_pkg::rfor_stat_t                   stat,
  output logic [rfor_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tuser
);
  import rfor_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int PW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int EW    = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
  localparam int XW    = (SW > 9) ? SW : 9;
  localparam int MW    = 9 + SW + 1;
  localparam int CA    = PW + FRAC_BITS + 2;
  localparam int CW    = (CA > 27) ? CA : 27;
  localparam logic [CW-1:0] OneU     = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [CW-1:0] FracMask = OneU - {{(CW-1){1'b0}}, 1'b1};

  // Truncation toward zero of a fixed-point value.
  function automatic logic signed [CW-1:0] fx_trunc(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] sh;
    sh = v >>> FRAC_BITS;
    if (v < 0 && (($unsigned(v) & FracMask) != '0)) begin
      fx_trunc = sh + $signed({{(CW-1){1'b0}}, 1'b1});
    end else begin
      fx_trunc = sh;
    end
  endfunction

  // Ceiling: the whole value itself, else the truncation of (v plus one).
  function automatic logic signed [CW-1:0] fx_ceil(input logic signed [CW-1:0] v);
    if (($unsigned(v) & FracMask) == '0) begin
      fx_ceil = v >>> FRAC_BITS;
    end else begin
      fx_ceil = fx_trunc(v + $signed(OneU));
    end
  endfunction

  // Clamp a size register to 1..MAX_SIDE.
  function automatic logic [SW-1:0] side_of(input logic [CFG_DATA_W-1:0] v);
    logic [EW-1:0] ext;
    ext = EW'(v);
    if (ext == '0) begin
      side_of = SW'(1);
    end else if (ext > EW'(MAX_SIDE)) begin
      side_of = SW'(MAX_SIDE);
    end else begin
      side_of = SW'(ext);
    end
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [7:0]            bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DATA_W'(1);
      height_r <= CFG_DATA_W'(1);
      bg_r     <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:      width_r  <= cfg_data;
        CFG_HEIGHT:     height_r <= cfg_data;
        CFG_BACKGROUND: bg_r     <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  logic [SW-1:0] w_eff, h_eff;
  assign w_eff = side_of(width_r);
  assign h_eff = side_of(height_r);

  // Captured command fields.
  logic [1:0]         op_r;
  logic [7:0]         shape_r, paint_r;
  logic signed [23:0] x_r, y_r, rw_r, rh_r;
  logic [8:0]         rpx_r, rpy_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_tuser;
      shape_r <= in_tdata[7:0];
      x_r     <= $signed(in_tdata[31:8]);
      y_r     <= $signed(in_tdata[55:32]);
      rw_r    <= $signed(in_tdata[79:56]);
      rh_r    <= $signed(in_tdata[103:80]);
      paint_r <= in_tdata[111:104];
      rpx_r   <= in_tdata[120:112];
      rpy_r   <= in_tdata[129:121];
    end
  end

  logic filled, draw_ok;
  assign filled  = (shape_r == SHAPE_FILLED);
  assign draw_ok = (filled || shape_r == SHAPE_OUTLINE) && (rw_r > 0) && (rh_r > 0);

  // Rectangle bounds and border lines, worked out once per draw.
  logic signed [CW-1:0] x_ext, y_ext, xe_sum, ye_sum;
  logic signed [CW-1:0] xe_r, ye_r, cx_r, tx_r, cy_r, ty_r;

  assign x_ext  = CW'(x_r);
  assign y_ext  = CW'(y_r);
  assign xe_sum = x_ext + CW'(rw_r);
  assign ye_sum = y_ext + CW'(rh_r);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      xe_r <= xe_sum;
      ye_r <= ye_sum;
      cx_r <= fx_ceil(x_ext);
      tx_r <= fx_trunc(xe_sum);
      cy_r <= fx_ceil(y_ext);
      ty_r <= fx_trunc(ye_sum);
    end
  end

  // Pixel scan counters; addr_r tracks py * width + px.
  logic [PW-1:0] px_r, py_r;
  logic [AW-1:0] addr_r;
  logic          last_x, last_y;

  assign last_x = (SW'(px_r) == (w_eff - SW'(1)));
  assign last_y = (SW'(py_r) == (h_eff - SW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.capture) begin
      px_r   <= '0;
      py_r   <= '0;
      addr_r <= '0;
    end else if (cmd.step) begin
      addr_r <= addr_r + AW'(1);
      if (last_x) begin
        px_r <= '0;
        py_r <= py_r + PW'(1);
      end else begin
        px_r <= px_r + PW'(1);
      end
    end
  end

  // Coverage test of the current pixel.
  logic signed [CW-1:0] px_s, py_s, fxp, fyp;
  logic                 in_area, border, mem_we;
  logic [7:0]           mem_wdata;

  assign px_s    = $signed({{(CW-PW){1'b0}}, px_r});
  assign py_s    = $signed({{(CW-PW){1'b0}}, py_r});
  assign fxp     = px_s <<< FRAC_BITS;
  assign fyp     = py_s <<< FRAC_BITS;
  assign in_area = (fxp >= x_ext) && (fxp <= xe_r) && (fyp >= y_ext) && (fyp <= ye_r);
  assign border  = (px_s == cx_r) || (px_s == tx_r) || (py_s == cy_r) || (py_s == ty_r);
  assign mem_we  = cmd.step && ((op_r == OP_CLEAR) || (in_area && (filled || border)));
  assign mem_wdata = (op_r == OP_CLEAR) ? bg_r : paint_r;

  // Read address and range check for a pixel read.
  logic [MW-1:0] rd_prod;
  logic [AW-1:0] raddr_r;
  logic          outside;

  assign rd_prod = MW'(rpy_r) * MW'(w_eff) + MW'(rpx_r);
  assign outside = (XW'(rpx_r) >= XW'(w_eff)) || (XW'(rpy_r) >= XW'(h_eff));

  always_ff @(posedge clk) begin
    if (cmd.rmul) begin
      raddr_r <= AW'(rd_prod);
    end
  end

  // Canvas memory: one write port, one registered read port.
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr_r];
  end

  // Result register.
  logic       res_status;
  logic [7:0] res_pixel;
  logic       out_status_r;
  logic [7:0] out_pixel_r;

  assign res_status = ((op_r == OP_DRAW) && !draw_ok) || ((op_r == OP_READ) && outside);
  assign res_pixel  = ((op_r == OP_READ) && !outside) ? rdata_r : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status;
      out_pixel_r  <= res_pixel;
    end
  end

  assign out_tdata = out_pixel_r;
  assign out_tuser = out_status_r;

  assign stat.op        = op_r;
  assign stat.draw_ok   = draw_ok;
  assign stat.scan_last = last_x && last_y;

endmodule

`default_nettype wire

// ===== rtl/core/rectangle_fill_outline_raster_core.sv =====
// Rectangle raster core: controller plus datapath over a byte-per-pixel canvas.
// A clear scans the canvas; a draw is set up and, if valid, scans it; a read forms
// its address and reads memory. No item is taken until the last result is loaded.
// The one-pixel-per-cycle canvas scan through the memory write port sets the rate.
// Reset (rst_n, synchronous, low) clears control and configuration; the canvas
// is undefined until a clear, with no clearing pass.
`default_nettype none

module rectangle_fill_outline_raster_core #(
  parameter int MAX_SIDE  = 512,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rfor_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rfor_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // shape, rect_x, rect_y, rect_width, rect_height, paint, pixel_x, pixel_y, zero pad
  input  wire logic [rfor_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op
  input  wire logic [rfor_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // pixel
  output logic [rfor_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status
  output logic                                   out_tuser
);
  import rfor_pkg::*;

  rfor_cmd_t  cmd;
  rfor_stat_t stat;

  rfor_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rfor_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

`include "rectangle_fill_outline_raster_core_assert.svh"

  // The block is not ready in the cycle after it accepts an item.
  `RFOR_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  // An error result never carries a pixel byte.
  `RFOR_ASSERT_IMP(a_err_no_pixel, out_tvalid && out_tuser, out_tdata == '0, "pixel on error")

  // Only clears and draws scan the canvas.
  `RFOR_ASSERT_IMP(a_scan_op, cmd.step, (stat.op == OP_CLEAR) || (stat.op == OP_DRAW), "bad scan")

endmodule

`default_nettype wire

// ===== dv/tb_rectangle_fill_outline_raster_core.sv =====
// Self-checking testbench for rectangle_fill_outline_raster_core: clear, draw and read items
// are checked against a cycle-free canvas predictor kept in the bench.
// Depends on rfor_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_rectangle_fill_outline_raster_core;
  import rfor_pkg::*;

  localparam int MAX_SIDE = 512;
  localparam int FRAC_BITS = 8;
  localparam longint FX_ONE = longint'(1) << FRAC_BITS;
  localparam int FX_ONE_INT = 1 << FRAC_BITS;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         shape;
    logic signed [23:0] rx;
    logic signed [23:0] ry;
    logic signed [23:0] rw;
    logic signed [23:0] rh;
    logic [7:0]         paint;
    logic [8:0]         pix_x;
    logic [8:0]         pix_y;
  } raster_cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] pixel;
  } raster_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Canvas predictor state: register copies and the pixel store.
  logic [9:0]     model_width;
  logic [9:0]     model_height;
  logic [7:0]     model_background;
  logic [7:0]     canvas_model [0:MAX_SIDE*MAX_SIDE-1];
  raster_result_t expected_results [$];

  int error_count = 0;
  int hold_cycles = 0;
  bit quiet = 1'b0;

  rectangle_fill_outline_raster_core #(
    .MAX_SIDE (MAX_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // A size register of zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned canvas_side(logic [9:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // Ceiling built from truncating divisions, so values below minus one with a fraction
  // land one step above the true ceiling.
  function automatic longint edge_ceil(longint v);
    longint t;
    t = v / FX_ONE;
    if (t * FX_ONE == v) return t;
    return (v + FX_ONE) / FX_ONE;
  endfunction

  // Predict the result of one accepted item and update the canvas copy.
  task automatic predict_raster(input raster_cmd_t c, output raster_result_t r);
    int unsigned w, h, px, py, i;
    longint x, y, xe, ye, cx, tx, cy, ty, fx, fy;
    bit filled, on_border;
    r.status = 1'b0;
    r.pixel = 8'd0;
    w = canvas_side(model_width);
    h = canvas_side(model_height);
    case (c.op)
      OP_CLEAR: begin
        for (i = 0; i < w * h; i++) canvas_model[i] = model_background;
      end
      OP_DRAW: begin
        x = c.rx;
        y = c.ry;
        filled = (c.shape == SHAPE_FILLED);
        if ((c.shape != SHAPE_FILLED && c.shape != SHAPE_OUTLINE) || c.rw <= 0 || c.rh <= 0) begin
          r.status = 1'b1;
        end else begin
          xe = x + longint'(c.rw);
          ye = y + longint'(c.rh);
          cx = edge_ceil(x);
          tx = xe / FX_ONE;
          cy = edge_ceil(y);
          ty = ye / FX_ONE;
          for (py = 0; py < h; py++) begin
            fy = longint'(py) * FX_ONE;
            if (fy < y || fy > ye) continue;
            for (px = 0; px < w; px++) begin
              fx = longint'(px) * FX_ONE;
              if (fx < x || fx > xe) continue;
              on_border = (longint'(px) == cx || longint'(px) == tx ||
                           longint'(py) == cy || longint'(py) == ty);
              if (filled || on_border) canvas_model[py * w + px] = c.paint;
            end
          end
        end
      end
      OP_READ: begin
        if (c.pix_x >= w || c.pix_y >= h) r.status = 1'b1;
        else r.pixel = canvas_model[c.pix_y * w + c.pix_x];
      end
      default: ;
    endcase
  endtask

  function automatic raster_cmd_t make_cmd(logic [1:0] op, logic [7:0] shape, int rx, int ry,
                                           int rw, int rh, logic [7:0] paint, int px, int py);
    raster_cmd_t c;
    c.op = op;
    c.shape = shape;
    c.rx = rx[23:0];
    c.ry = ry[23:0];
    c.rw = rw[23:0];
    c.rh = rh[23:0];
    c.paint = paint;
    c.pix_x = px[8:0];
    c.pix_y = py[8:0];
    return c;
  endfunction

  // Random item, mostly well-formed draws and reads near the current canvas.
  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    int unsigned w, h, pick;
    int x, y, sw, sh;
    w = canvas_side(model_width);
    h = canvas_side(model_height);
    c = make_cmd(OP_DRAW, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
                 8'($urandom), $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
      x = int'($urandom_range(0, (w + 4) * FX_ONE_INT)) - 3 * FX_ONE_INT;
      y = int'($urandom_range(0, (h + 4) * FX_ONE_INT)) - 3 * FX_ONE_INT;
      sw = int'($urandom_range(1, (w + 3) * FX_ONE_INT));
      sh = int'($urandom_range(1, (h + 3) * FX_ONE_INT));
      c.rx = x[23:0];
      c.ry = y[23:0];
      c.rw = sw[23:0];
      c.rh = sh[23:0];
    end else if (pick < 55) begin
      // Broken draw: bad type byte or a size that is not positive.
      sw = -int'($urandom_range(0, 4 * FX_ONE_INT));
      case ($urandom_range(0, 2))
        0: if (c.shape == SHAPE_FILLED || c.shape == SHAPE_OUTLINE) c.shape = 8'h00;
        1: begin
          c.shape = SHAPE_FILLED;
          c.rw = sw[23:0];
        end
        default: begin
          c.shape = SHAPE_OUTLINE;
          c.rh = sw[23:0];
        end
      endcase
    end else if (pick < 60) begin
      c.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
    end else if (pick < 88) begin
      c.op = OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        c.pix_x = 9'($urandom_range(0, w - 1));
        c.pix_y = 9'($urandom_range(0, h - 1));
      end
    end else if (pick < 94) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // Offer one item, record its expected result once accepted, then maybe idle.
  task automatic send_item(input raster_cmd_t c);
    raster_result_t r;
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, c.pix_y, c.pix_x, c.paint, c.rh, c.rw, c.ry, c.rx, c.shape};
    in_tuser <= c.op;
    do @(posedge clk); while (!in_tready);
    predict_raster(c, r);
    expected_results.push_back(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers while the core is idle.
  task automatic set_canvas(input logic [9:0] w, input logic [9:0] h, input logic [7:0] bg);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_data <= {2'd0, bg};
    @(posedge clk);
    cfg_we <= 1'b0;
    model_width = w;
    model_height = h;
    model_background = bg;
  endtask

  // Reset values: a one-pixel canvas with background 32.
  task automatic test_reset_defaults();
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, 0, 0, 256, 256, 8'h3c, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Size registers of zero behave as one.
  task automatic test_zero_sizes();
    set_canvas(10'd0, 10'd0, 8'h00);
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Directed draws: both shapes, bad types, bad sizes, negative ceilings,
  // field extremes and reads at and beyond the canvas edge.
  task automatic test_draw_cases();
    set_canvas(10'd8, 10'd6, 8'hff);
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, 256, 256, 768, 512, 8'h11, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_OUTLINE, -384, 128, 2112, 1216, 8'haa, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_OUTLINE, 512, 512, 128, 128, 8'h77, 0, 0));
    send_item(make_cmd(OP_DRAW, 8'h00, 0, 0, 512, 512, 8'h01, 0, 0));
    send_item(make_cmd(OP_DRAW, 8'hff, 0, 0, 512, 512, 8'h02, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, 0, 0, 0, 512, 8'h03, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, 0, 0, 512, -1, 8'h04, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_OUTLINE, 0, 0, -8388608, 512, 8'h05, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, -8388608, -8388608, 8388607, 8388607, 8'h00,
                       0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_OUTLINE, 8388607, 0, 256, 256, 8'h06, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 7, 5));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, 0, 0, 8388607, 8388607, 8'h5c, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 3, 2));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 6));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 511, 511));
    send_item(make_cmd(OP_UNUSED, 8'hff, -1, -1, -1, -1, 8'hff, 511, 511));
  endtask

  // Largest side on each axis, the width through an oversized register value.
  task automatic test_large_sides();
    set_canvas(10'd1023, 10'd2, 8'h81);
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_OUTLINE, 128000, 0, 3000, 256, 8'h42, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 511, 1));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 500, 0));
    set_canvas(10'd1, 10'd512, 8'h7e);
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_DRAW, SHAPE_FILLED, -100, 130000, 200, 1000, 8'hc3, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 511));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 508));
  endtask

  // Random items over several small canvases, each started with a clear.
  task automatic test_random_mix();
    int n, k;
    for (n = 0; n < 6; n++) begin
      if (n == 0) begin
        set_canvas(10'($urandom_range(1, 4)), 10'($urandom_range(1, 4)), 8'($urandom));
      end else begin
        set_canvas(10'($urandom_range(1, 24)), 10'($urandom_range(1, 24)), 8'($urandom));
      end
      send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      for (k = 0; k < 6; k++) send_item(random_cmd());
    end
  endtask

  // Receiver holds off while items keep coming, then the sender waits for all results.
  task automatic test_backpressure();
    int k;
    set_canvas(10'd5, 10'd3, 8'h99);
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    hold_cycles = 400;
    for (k = 0; k < 6; k++) send_item(random_cmd());
    drain();
    for (k = 0; k < 4; k++) send_item(random_cmd());
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_steady_stream();
    int k;
    set_canvas(10'd16, 10'd16, 8'h10);
    quiet = 1'b1;
    send_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (k = 0; k < 15; k++) send_item(random_cmd());
  endtask

  // Stimulus sequence and end of run.
  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    model_width = 10'd1;
    model_height = 10'd1;
    model_background = 8'd32;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    test_reset_defaults();
    test_zero_sizes();
    test_draw_cases();
    test_large_sides();
    test_random_mix();
    test_backpressure();
    test_steady_stream();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result-side ready: a long hold when asked, random short stalls otherwise.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    raster_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d pixel 0x%02h", out_tuser, out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, out_tuser);
          error_count++;
        end
        if (out_tdata !== exp_r.pixel) begin
          $error("pixel mismatch: expected 0x%02h, actual 0x%02h", exp_r.pixel, out_tdata);
          error_count++;
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rfor_pkg.sv
rtl/core/rfor_ctrl.sv
rtl/core/rfor_datapath.sv
rtl/core/rectangle_fill_outline_raster_core.sv
dv/tb_rectangle_fill_outline_raster_core.sv
